FILE: sv/mlsw_pkg.sv
// ----------------------------------------------------------------------------
// mlsw_pkg
// Shared types and constants for the learning switch MAC table.
// ----------------------------------------------------------------------------
`default_nettype none
package mlsw_pkg;
    localparam int NUM_PORTS_DEF     = 8;
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 32;

    localparam logic [CFG_IDX_W-1:0] REG_AGING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DATA  = 2'd2;

    localparam logic [1:0] ACT_FORWARD = 2'd0;
    localparam logic [1:0] ACT_FLOOD   = 2'd1;
    localparam logic [1:0] ACT_DROP    = 2'd2;

    // classified command from front to back
    typedef enum logic [1:0] {
        CMD_DROP = 2'd0,
        CMD_TICK = 2'd1,
        CMD_DATA = 2'd2
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [3:0]  in_port;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
    } t_job;
endpackage
`default_nettype wire

FILE: sv/mlsw_front.sv
// ----------------------------------------------------------------------------
// mlsw_front
// Accepts headers, classifies them, and queues jobs for the table engine.
// ----------------------------------------------------------------------------
`default_nettype none
module mlsw_front #(
    parameter int NUM_PORTS = mlsw_pkg::NUM_PORTS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [3:0]          i_in_port,
    input  wire logic [47:0]         i_src_mac,
    input  wire logic [47:0]         i_dst_mac,
    input  wire logic [15:0]         i_frame_type,
    input  wire logic [15:0]         i_ctrl_code,
    input  wire logic [15:0]         i_data_code,
    output logic                     o_job_valid,
    output mlsw_pkg::t_job           o_job,
    input  wire logic                i_job_take
);
    import mlsw_pkg::*;

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job       w_job;

    // classification
    always_comb begin
        w_job.in_port = i_in_port;
        w_job.src_mac = i_src_mac;
        w_job.dst_mac = i_dst_mac;
        if (i_frame_type == i_ctrl_code) begin
            w_job.cmd = CMD_TICK;
        end else if (i_frame_type == i_data_code && i_in_port != 4'd0 &&
                     i_in_port <= 4'(NUM_PORTS)) begin
            w_job.cmd = CMD_DATA;
        end else begin
            w_job.cmd = CMD_DROP;
        end
    end

    assign full        = (r_cnt == 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    // two-entry job queue
    always_ff @(posedge i_clk) begin
        if (push && !full) begin
            r_q[r_wp] <= w_job;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push && !full) r_wp <= ~r_wp;
            if (i_job_take)    r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'((push && !full) ? 1 : 0) - 2'(i_job_take ? 1 : 0);
        end
    end
endmodule
`default_nettype wire

FILE: sv/mlsw_ram.sv
// ----------------------------------------------------------------------------
// mlsw_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module mlsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: sv/mlsw_back.sv
// ----------------------------------------------------------------------------
// mlsw_back
// Table engine: ticks, learns source, looks up destination by scanning.
// ----------------------------------------------------------------------------
`default_nettype none
module mlsw_back #(
    parameter int TABLE_ENTRIES = mlsw_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_job_valid,
    input  wire mlsw_pkg::t_job i_job,
    output logic             o_job_take,
    input  wire logic [31:0] i_aging,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_action,
    output logic [3:0]       o_out_port
);
    import mlsw_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int RW = 48 + 4 + 32;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN1 = 5'b00010,
        S_WRITE = 5'b00100,
        S_SCAN2 = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    t_job              r_job;
    logic [31:0]       r_tick;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [AW:0]       r_idx;      // address issued
    logic              r_rd_vld;   // read data of r_cidx valid
    logic [AW-1:0]     r_cidx;     // index of data on ram output
    logic              r_hit, r_free_f;
    logic [AW-1:0]     r_hit_i, r_free_i;
    logic              r_res_vld;
    logic [1:0]        r_act;
    logic [3:0]        r_port;

    logic              w_we;
    logic [AW-1:0]     w_addr, w_waddr;
    logic [RW-1:0]     w_wdata, w_rdata;
    logic [47:0]       w_mac;
    logic [3:0]        w_eport;
    logic [31:0]       w_exp;
    logic [32:0]       w_sum;
    logic              w_match, w_expired, w_key_hit, w_last;

    assign w_mac   = w_rdata[RW-1 -: 48];
    assign w_eport = w_rdata[35:32];
    assign w_exp   = w_rdata[31:0];
    assign w_expired = (w_exp <= r_tick);
    assign w_key_hit = r_valid[r_cidx] &&
                       (w_mac == ((r_state == S_SCAN1) ? r_job.src_mac : r_job.dst_mac));
    assign w_sum   = {1'b0, r_tick} + {1'b0, i_aging};
    assign w_waddr = r_hit ? r_hit_i : r_free_i;
    assign w_wdata = {r_job.src_mac, r_job.in_port,
                      w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0]};
    assign w_we    = (r_state == S_WRITE) && (r_hit || r_free_f);
    assign w_addr  = w_we ? w_waddr : r_idx[AW-1:0];
    assign w_last  = (r_cidx == AW'(TABLE_ENTRIES - 1));
    assign w_match = r_rd_vld && w_key_hit;

    mlsw_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    assign o_job_take = (r_state == S_IDLE) && i_job_valid && !r_res_vld;
    assign empty      = !r_res_vld;
    assign o_action   = r_act;
    assign o_out_port = r_port;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_job_take && i_job.cmd == CMD_DATA) n_state = S_SCAN1;
            end
            S_SCAN1: begin
                if (r_rd_vld && (w_key_hit || w_last)) n_state = S_WRITE;
            end
            S_WRITE: n_state = S_SCAN2;
            S_SCAN2: begin
                if (r_rd_vld && (w_key_hit || w_last)) n_state = S_DONE;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // engine registers
    always_ff @(posedge i_clk) begin
        if (o_job_take) r_job <= i_job;
        r_cidx <= r_idx[AW-1:0];
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tick    <= 32'd0;
            r_valid   <= '0;
            r_res_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_free_f  <= 1'b0;
            r_hit_i   <= '0;
            r_free_i  <= '0;
            r_act     <= ACT_DROP;
            r_port    <= 4'd0;
        end else begin
            r_state <= n_state;
            if (pop && r_res_vld) r_res_vld <= 1'b0;
            r_rd_vld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_idx    <= '0;
                    r_hit    <= 1'b0;
                    r_free_f <= 1'b0;
                    if (o_job_take) begin
                        if (i_job.cmd == CMD_DATA) begin
                            r_idx    <= (AW+1)'(1);
                            r_rd_vld <= 1'b1;
                        end else begin
                            if (i_job.cmd == CMD_TICK && r_tick != 32'hFFFF_FFFF)
                                r_tick <= r_tick + 32'd1;
                            r_act     <= ACT_DROP;
                            r_port    <= 4'd0;
                            r_res_vld <= 1'b1;
                        end
                    end
                end
                S_SCAN1: begin
                    if (r_rd_vld) begin
                        if (w_key_hit) begin
                            r_hit   <= 1'b1;
                            r_hit_i <= r_cidx;
                        end else if (!r_free_f && (!r_valid[r_cidx] || w_expired)) begin
                            r_free_f <= 1'b1;
                            r_free_i <= r_cidx;
                        end
                        if (!(w_key_hit || w_last)) begin
                            r_idx    <= r_idx + (AW+1)'(1);
                            r_rd_vld <= 1'b1;
                        end
                    end
                end
                S_WRITE: begin
                    if (w_we) r_valid[w_waddr] <= 1'b1;
                    r_idx <= '0;
                end
                S_SCAN2: begin
                    if (r_idx == '0 && !r_rd_vld) begin
                        r_idx    <= (AW+1)'(1);
                        r_rd_vld <= 1'b1;
                    end else if (r_rd_vld) begin
                        if (w_match) begin
                            if (w_expired) begin
                                r_act <= ACT_FLOOD; r_port <= 4'd0;
                            end else if (w_eport == r_job.in_port) begin
                                r_act <= ACT_DROP;  r_port <= 4'd0;
                            end else begin
                                r_act <= ACT_FORWARD; r_port <= w_eport;
                            end
                        end else if (w_last) begin
                            r_act <= ACT_FLOOD; r_port <= 4'd0;
                        end else begin
                            r_idx    <= r_idx + (AW+1)'(1);
                            r_rd_vld <= 1'b1;
                        end
                    end
                end
                S_DONE: r_res_vld <= 1'b1;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: sv/mac_learning_switch_with_aging_core.sv
// ----------------------------------------------------------------------------
// mac_learning_switch_with_aging_core
// Learning switch MAC table with tick-based aging.
//
// Channel | Direction | Handshake   | Payload
// input   | in        | push/full   | in_port, src_mac, dst_mac, frame_type
// result  | out       | pop/empty   | action, out_port
// config  | in        | i_cfg_we    | i_cfg_idx, i_cfg_data
//
// Control and dropped frames: the engine registers a drop result when it takes
// the job. Data frames: the result follows two linear scans of the single-port
// table RAM (each stops early on a hit). The engine takes no new job while a
// result waits to be popped.
// Synchronous active-low reset clears valid bits, tick count and queues.
// A two-entry job queue lets headers be accepted while the table engine is busy
// or a result waits to be popped.
// ----------------------------------------------------------------------------
`default_nettype none
module mac_learning_switch_with_aging_core #(
    parameter int NUM_PORTS     = mlsw_pkg::NUM_PORTS_DEF,
    parameter int TABLE_ENTRIES = mlsw_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [3:0]                    i_in_port,
    input  wire logic [47:0]                   i_src_mac,
    input  wire logic [47:0]                   i_dst_mac,
    input  wire logic [15:0]                   i_frame_type,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [1:0]                         o_action,
    output logic [3:0]                         o_out_port,
    input  wire logic                          i_cfg_we,
    input  wire logic [mlsw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mlsw_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mlsw_pkg::*;

    logic [31:0] r_aging;
    logic [15:0] r_ctrl, r_data;
    logic        w_job_valid, w_job_take;
    t_job        w_job;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aging <= 32'd10;
            r_ctrl  <= 16'd1;
            r_data  <= 16'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_AGING: r_aging <= i_cfg_data;
                REG_CTRL:  r_ctrl  <= i_cfg_data[15:0];
                REG_DATA:  r_data  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    mlsw_front #(.NUM_PORTS(NUM_PORTS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_port   (i_in_port),
        .i_src_mac   (i_src_mac),
        .i_dst_mac   (i_dst_mac),
        .i_frame_type(i_frame_type),
        .i_ctrl_code (r_ctrl),
        .i_data_code (r_data),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_take  (w_job_take)
    );

    mlsw_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(w_job_valid),
        .i_job      (w_job),
        .o_job_take (w_job_take),
        .i_aging    (r_aging),
        .empty      (empty),
        .pop        (pop),
        .o_action   (o_action),
        .o_out_port (o_out_port)
    );
endmodule
`default_nettype wire

FILE: dv/mac_learning_switch_with_aging_core_tb.sv
// ----------------------------------------------------------------------------
// mac_learning_switch_with_aging_core_tb
// Self-checking bench for the learning switch MAC table. A directed table of
// headers covers address and port extremes, bad ports, unknown types and
// aging. Random phases follow under several register settings: zero and
// maximum aging, equal type codes, and a table filled past capacity. Each
// result is checked against its directed row or a bench model of the table.
// ----------------------------------------------------------------------------
`default_nettype none
module mac_learning_switch_with_aging_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mlsw_pkg::*;

    localparam int NPORTS  = NUM_PORTS_DEF;
    localparam int NENTRY  = TABLE_ENTRIES_DEF;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 2 * NENTRY + 20;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic [3:0]  port;
        logic [47:0] src;
        logic [47:0] dst;
        logic [15:0] etype;
    } t_frame;

    typedef struct {
        t_frame      f;
        bit          typed;
        logic [1:0]  act;
        logic [3:0]  egress;
    } t_row;

    typedef struct {
        logic [1:0] act;
        logic [3:0] egress;
    } t_verdict;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [3:0]            i_in_port;
    logic [47:0]           i_src_mac;
    logic [47:0]           i_dst_mac;
    logic [15:0]           i_frame_type;
    logic                  empty;
    logic                  pop;
    logic [1:0]            o_action;
    logic [3:0]            o_out_port;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mac_learning_switch_with_aging_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_in_port    (i_in_port),
        .i_src_mac    (i_src_mac),
        .i_dst_mac    (i_dst_mac),
        .i_frame_type (i_frame_type),
        .empty        (empty),
        .pop          (pop),
        .o_action     (o_action),
        .o_out_port   (o_out_port),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Shadow of the switch state
    logic [31:0] aging_sh;
    logic [15:0] ctrl_sh;
    logic [15:0] data_sh;
    logic [31:0] tick_sh;
    bit          valid_sh [NENTRY];
    logic [47:0] mac_sh   [NENTRY];
    logic [3:0]  port_sh  [NENTRY];
    logic [31:0] expiry_sh[NENTRY];

    t_verdict    verdict_q[$];
    t_row        directed_q[$];
    logic [47:0] mac_pool[128];
    int          pool_size;
    int          ctrl_pct;
    int          pop_pct;
    int          mismatches;
    int          n_sent;
    int          n_results;
    int          n_fwd, n_flood, n_drop;
    int          idle_cycles;

    function automatic int lookup_mac(input logic [47:0] mac);
        for (int i = 0; i < NENTRY; i++)
            if (valid_sh[i] && mac_sh[i] == mac) return i;
        return -1;
    endfunction

    function automatic void learn_source(input logic [47:0] mac, input logic [3:0] port);
        int         slot;
        logic [32:0] sum;
        slot = lookup_mac(mac);
        if (slot < 0) begin
            for (int i = 0; i < NENTRY; i++) begin
                if (!valid_sh[i] || expiry_sh[i] <= tick_sh) begin
                    slot = i;
                    break;
                end
            end
        end
        if (slot < 0) return;
        sum = {1'b0, tick_sh} + {1'b0, aging_sh};
        if (sum[32]) sum = {1'b0, 32'hFFFF_FFFF};
        valid_sh[slot]  = 1'b1;
        mac_sh[slot]    = mac;
        port_sh[slot]   = port;
        expiry_sh[slot] = sum[31:0];
    endfunction

    // Forwarding decision for one accepted header; updates the shadow state
    function automatic t_verdict switch_frame(input t_frame f);
        t_verdict v;
        int       d;
        v.act    = ACT_DROP;
        v.egress = 4'd0;
        if (f.etype == ctrl_sh) begin
            if (tick_sh != 32'hFFFF_FFFF) tick_sh++;
        end else if (f.etype == data_sh && f.port >= 1 && f.port <= NPORTS) begin
            learn_source(f.src, f.port);
            d = lookup_mac(f.dst);
            if (d < 0 || expiry_sh[d] <= tick_sh) begin
                v.act = ACT_FLOOD;
            end else if (port_sh[d] != f.port) begin
                v.act    = ACT_FORWARD;
                v.egress = port_sh[d];
            end
        end
        return v;
    endfunction

    function automatic logic [47:0] pick_mac();
        if ($urandom_range(0, 99) < 80) return mac_pool[$urandom_range(0, pool_size - 1)];
        return 48'({$urandom, $urandom});
    endfunction

    function automatic t_frame random_frame();
        t_frame f;
        int     r;
        r = $urandom_range(0, 99);
        f.port = ($urandom_range(0, 99) < 90) ? 4'($urandom_range(1, NPORTS))
                                               : 4'($urandom_range(0, 15));
        f.src  = pick_mac();
        f.dst  = pick_mac();
        if (r < ctrl_pct)           f.etype = ctrl_sh;
        else if (r < 95)            f.etype = data_sh;
        else                        f.etype = 16'($urandom);
        return f;
    endfunction

    task automatic add_row(input logic [3:0] port, input logic [47:0] src,
                           input logic [47:0] dst, input logic [15:0] etype,
                           input bit typed, input logic [1:0] act,
                           input logic [3:0] egress);
        t_row r;
        r.f      = '{port, src, dst, etype};
        r.typed  = typed;
        r.act    = act;
        r.egress = egress;
        directed_q.push_back(r);
    endtask

    // Sender: one transaction, held until accepted
    task automatic send_frame(input t_frame f, input bit typed, input t_verdict typed_v);
        t_verdict v;
        @(negedge i_clk);
        push         <= 1'b1;
        i_in_port    <= f.port;
        i_src_mac    <= f.src;
        i_dst_mac    <= f.dst;
        i_frame_type <= f.etype;
        do @(posedge i_clk); while (full);
        v = switch_frame(f);
        verdict_q.push_back(typed ? typed_v : v);
        n_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge i_clk);
        push <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Wait for every result, then let the engine settle before touching registers
    task automatic wait_drained();
        pause_sender(1);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == REG_AGING)     aging_sh = value;
        else if (idx == REG_CTRL) ctrl_sh  = value[15:0];
        else if (idx == REG_DATA) data_sh  = value[15:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int count);
        int       burst;
        t_verdict dummy;
        dummy = '{ACT_DROP, 4'd0};
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 300));
                burst = $urandom_range(1, 12);
            end
            send_frame(random_frame(), 1'b0, dummy);
            burst--;
        end
    endtask

    // Receiver stall pattern: pop rate switches at random among 100, 60 and 15 percent
    always @(negedge i_clk) begin
        if ($urandom_range(0, 299) == 0) begin
            case ($urandom_range(0, 2))
                0: pop_pct = 100;
                1: pop_pct = 60;
                default: pop_pct = 15;
            endcase
        end
        pop <= ($urandom_range(0, 99) < pop_pct);
    end

    // Result checker
    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n && pop && !empty) begin
            n_results++;
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result action=%0d port=%0d",
                             o_action, o_out_port);
            end else begin
                exp_v = verdict_q.pop_front();
                if (exp_v.act == ACT_FORWARD) n_fwd++;
                else if (exp_v.act == ACT_FLOOD) n_flood++;
                else n_drop++;
                if (o_action !== exp_v.act || o_out_port !== exp_v.egress) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d exp action=%0d port=%0d %s=%0d port=%0d",
                                 n_results, exp_v.act, exp_v.egress, "got action",
                                 o_action, o_out_port);
                end
            end
        end
    end

    // Watchdog on transactions
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // Main sequence
    initial begin
        logic [47:0] ma, mb, mc, md;
        t_verdict    tv;
        push = 1'b0; i_in_port = '0; i_src_mac = '0; i_dst_mac = '0; i_frame_type = '0;
        pop = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        pop_pct = 100; ctrl_pct = 10; pool_size = 16;
        mismatches = 0; n_sent = 0; n_results = 0; n_fwd = 0; n_flood = 0; n_drop = 0;
        idle_cycles = 0;
        aging_sh = 32'd10; ctrl_sh = 16'd1; data_sh = 16'd2; tick_sh = '0;
        for (int i = 0; i < NENTRY; i++) valid_sh[i] = 1'b0;
        for (int i = 0; i < 128; i++) mac_pool[i] = 48'({$urandom, $urandom});

        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, reset register values
        ma = 48'h0000_0000_0000; mb = 48'hFFFF_FFFF_FFFF;
        mc = 48'h0123_4567_89AB; md = 48'h8000_0000_0001;
        add_row(4'd1,  ma, mb, 16'd2,    1'b1, ACT_FLOOD,   4'd0); // empty table
        add_row(4'd8,  mb, ma, 16'd2,    1'b1, ACT_FORWARD, 4'd1);
        add_row(4'd1,  ma, mb, 16'd2,    1'b1, ACT_FORWARD, 4'd8);
        add_row(4'd1,  mc, ma, 16'd2,    1'b1, ACT_DROP,    4'd0); // same port
        add_row(4'd3,  md, md, 16'd2,    1'b1, ACT_DROP,    4'd0); // source is destination
        add_row(4'd0,  mc, mb, 16'd2,    1'b1, ACT_DROP,    4'd0); // bad ingress ports
        add_row(4'd9,  mc, mb, 16'd2,    1'b1, ACT_DROP,    4'd0);
        add_row(4'd15, mc, mb, 16'd2,    1'b1, ACT_DROP,    4'd0);
        add_row(4'd2,  mc, mb, 16'hFFFF, 1'b1, ACT_DROP,    4'd0); // unknown types
        add_row(4'd2,  mc, mb, 16'h0000, 1'b1, ACT_DROP,    4'd0);
        add_row(4'd0,  mb, ma, 16'd1,    1'b1, ACT_DROP,    4'd0); // ticks
        add_row(4'd15, ma, mb, 16'd1,    1'b1, ACT_DROP,    4'd0);
        add_row(4'd2,  mc, mb, 16'd2,    1'b0, ACT_DROP,    4'd0);
        for (int i = 0; i < 10; i++)
            add_row(4'($urandom_range(0, 15)), mc, md, 16'd1, 1'b1, ACT_DROP, 4'd0);
        add_row(4'd2,  ma, mb, 16'd2,    1'b0, ACT_DROP,    4'd0); // aged out
        add_row(4'd4,  mb, ma, 16'd2,    1'b0, ACT_DROP,    4'd0);
        foreach (directed_q[i]) begin
            tv = '{directed_q[i].act, directed_q[i].egress};
            send_frame(directed_q[i].f, directed_q[i].typed, tv);
        end

        // Reset settings, small address pool
        run_random(250);

        // Zero aging, type codes at opposite extremes
        wait_drained();
        write_reg(REG_AGING, 32'd0);
        write_reg(REG_CTRL, 32'h0000_FFFF);
        write_reg(REG_DATA, 32'h0000_0000);
        run_random(100);

        // Maximum aging, more live addresses than table entries
        wait_drained();
        write_reg(REG_AGING, 32'hFFFF_FFFF);
        write_reg(REG_CTRL, 32'h0000_8100);
        write_reg(REG_DATA, 32'h0000_0800);
        pool_size = 100; ctrl_pct = 3;
        run_random(300);

        // Equal type codes; spare index must be ignored
        wait_drained();
        write_reg(REG_AGING, 32'd3);
        write_reg(REG_CTRL, 32'h0000_1234);
        write_reg(REG_DATA, 32'h0000_1234);
        write_reg(REG_SPARE, 32'hDEAD_BEEF);
        pool_size = 16; ctrl_pct = 20;
        run_random(100);

        // Short aging with frequent ticks
        wait_drained();
        write_reg(REG_AGING, 32'd5);
        write_reg(REG_CTRL, 32'd1);
        write_reg(REG_DATA, 32'd2);
        pool_size = 24; ctrl_pct = 15;
        run_random(300);

        wait_drained();
        $display("Covered %0d headers over five register settings", n_sent);
        $display("Forwarded %0d, flooded %0d, dropped %0d; checked %0d, mismatches %0d",
                 n_fwd, n_flood, n_drop, n_results, mismatches);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
sv/mlsw_pkg.sv
sv/mlsw_front.sv
sv/mlsw_ram.sv
sv/mlsw_back.sv
sv/mac_learning_switch_with_aging_core.sv
dv/mac_learning_switch_with_aging_core_tb.sv
